// File: design/hfdl_pkg.sv
// hfdl_pkg: shared widths, constants and types of the fractional delay line
// no dependencies; used by the interfaces, the interpolator and the top level
`timescale 1ns / 1ps

package hfdl_pkg;

    localparam int SAMPLE_W = 24;
    localparam int DELAY_W  = 28;
    localparam int FRAC_W   = 16;
    localparam int COEF_W   = 28;
    localparam int OPND_W   = 30;
    localparam int ACC_W    = 48;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] ROUND_OUT  = ACC_W'(65536);
    localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] SAT_LO     = -ACC_W'(8388608);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_WAIT,
        ST_COEF,
        ST_MUL3,
        ST_MUL2,
        ST_MUL1,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MS_C3,
        MS_A,
        MS_B
    } mstep_t;

    typedef struct packed {
        logic       y_load;
        logic [1:0] y_sel;
        logic       coef_load;
        logic       mul_en;
        mstep_t     step;
    } interp_ctrl_t;

endpackage

// File: design/hfdl_if.sv
// hfdl_item_if and hfdl_result_if: valid/ready channels of the delay line
// depends on hfdl_pkg for the payload widths
`timescale 1ns / 1ps

interface hfdl_item_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  channel;
    logic signed [hfdl_pkg::SAMPLE_W-1:0]  sample_in;
    logic        [hfdl_pkg::DELAY_W-1:0]   delay_amount;
    logic                                  frame_end;

    modport source (output valid, output channel, output sample_in,
                    output delay_amount, output frame_end, input ready);
    modport sink   (input valid, input channel, input sample_in,
                    input delay_amount, input frame_end, output ready);
endinterface

interface hfdl_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [hfdl_pkg::SAMPLE_W-1:0]  sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// File: design/hfdl_interp.sv
// hfdl_interp: hermite coefficient build and horner evaluation on one shared multiplier
// depends on hfdl_pkg; sequenced by the top level through interp_ctrl_t
`timescale 1ns / 1ps

module hfdl_interp
(
    input  logic                                 clk,
    input  hfdl_pkg::interp_ctrl_t               ctrl,
    input  logic        [hfdl_pkg::FRAC_W-1:0]   t,
    input  logic signed [hfdl_pkg::SAMPLE_W-1:0] y_in,
    output logic signed [hfdl_pkg::SAMPLE_W-1:0] sample
);

    localparam int SW = hfdl_pkg::SAMPLE_W;
    localparam int CW = hfdl_pkg::COEF_W;
    localparam int OW = hfdl_pkg::OPND_W;
    localparam int AW = hfdl_pkg::ACC_W;
    localparam int FW = hfdl_pkg::FRAC_W;

    logic signed [SW-1:0] y_reg [4];
    logic signed [CW-1:0] c3_reg;
    logic signed [CW-1:0] c2_reg;
    logic signed [CW-1:0] c1_reg;
    logic signed [CW-1:0] c0_reg;
    logic signed [AW-1:0] prod_reg;

    logic signed [CW-1:0] y0e;
    logic signed [CW-1:0] y1e;
    logic signed [CW-1:0] y2e;
    logic signed [CW-1:0] y3e;
    logic signed [CW-1:0] d12;
    logic signed [CW-1:0] c3_next;
    logic signed [CW-1:0] c2_next;
    logic signed [CW-1:0] c1_next;
    logic signed [CW-1:0] c0_next;

    logic signed [AW-1:0] sum_a;
    logic signed [AW-1:0] sum_b;
    logic signed [AW-1:0] sum_r;
    logic signed [AW-1:0] a_full;
    logic signed [AW-1:0] b_full;
    logic signed [AW-1:0] r_full;
    logic signed [OW-1:0] m_op;
    logic signed [FW:0]   t_s;
    logic signed [AW-1:0] prod_next;

    // twice-scale catmull-rom coefficients
    always_comb
    begin
        y0e     = CW'(y_reg[0]);
        y1e     = CW'(y_reg[1]);
        y2e     = CW'(y_reg[2]);
        y3e     = CW'(y_reg[3]);
        d12     = y1e - y2e;
        c3_next = (y3e - y0e) + (d12 <<< 1) + d12;
        c2_next = (y0e <<< 1) - ((y1e <<< 2) + y1e) + (y2e <<< 2) - y3e;
        c1_next = y2e - y0e;
        c0_next = y1e <<< 1;
    end

    // horner steps, each rounding to nearest with ties upward
    always_comb
    begin
        sum_a  = prod_reg + (AW'(c2_reg) <<< FW) + hfdl_pkg::ROUND_HALF;
        a_full = sum_a >>> FW;
        sum_b  = prod_reg + (AW'(c1_reg) <<< FW) + hfdl_pkg::ROUND_HALF;
        b_full = sum_b >>> FW;
        sum_r  = prod_reg + (AW'(c0_reg) <<< FW) + hfdl_pkg::ROUND_OUT;
        r_full = sum_r >>> (FW + 1);
        t_s    = $signed({1'b0, t});
        case (ctrl.step)
            hfdl_pkg::MS_C3: m_op = OW'(c3_reg);
            hfdl_pkg::MS_A:  m_op = a_full[OW-1:0];
            hfdl_pkg::MS_B:  m_op = b_full[OW-1:0];
            default:         m_op = '0;
        endcase
        prod_next = m_op * t_s;
    end

    always_comb
    begin
        if (r_full > hfdl_pkg::SAT_HI)
        begin
            sample = hfdl_pkg::SAT_HI[SW-1:0];
        end
        else if (r_full < hfdl_pkg::SAT_LO)
        begin
            sample = hfdl_pkg::SAT_LO[SW-1:0];
        end
        else
        begin
            sample = r_full[SW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.y_load)
        begin
            y_reg[ctrl.y_sel] <= y_in;
        end
        if (ctrl.coef_load)
        begin
            c3_reg <= c3_next;
            c2_reg <= c2_next;
            c1_reg <= c1_next;
            c0_reg <= c0_next;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

// File: design/hermite_fractional_delay_line.sv
// hermite_fractional_delay_line: per-channel ring buffer with a cubic fractional read
// depends on hfdl_pkg, hfdl_if (hfdl_item_if, hfdl_result_if) and hfdl_interp
`timescale 1ns / 1ps

// usage
//   item channel: one word carries channel, sample_in (q1.23), delay_amount (u12.16)
//   and frame_end. the sample is stored at the shared write position of its channel,
//   then the line is read delay_amount samples back with 4-point hermite interpolation.
//   result channel: one word per item, sample_out (q1.23, saturated).
//   timing: items are taken one at a time. per item the sequencer runs address, four
//   reads, a wait for the registered read data, coefficient load, three horner steps
//   and result load, set by the ring memory's single read port and shared multiplier.
//   a new item is taken while the previous result still waits in the output register;
//   if that result is still not taken when the next one is ready, the sequencer
//   holds and item.ready stays low until the receiver takes it.
//   reset: after rst_n releases, a clearing pass zeroes the ring memory, one entry per
//   cycle, over all min(CHANNELS, 2) * DEPTH entries; item.ready is low during it.
//   the write position starts at zero and advances after a word with frame_end set.

module hermite_fractional_delay_line
#(
    parameter int DEPTH    = 4096,
    parameter int CHANNELS = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    hfdl_item_if.sink            item,
    hfdl_result_if.source        result
);

    localparam int USED_CH   = (CHANNELS > 1) ? 2 : 1;
    localparam int MEM_DEPTH = USED_CH * DEPTH;
    localparam int AW        = $clog2(DEPTH);
    localparam int MW        = $clog2(MEM_DEPTH);
    localparam int FW        = hfdl_pkg::FRAC_W;
    localparam int SW        = hfdl_pkg::SAMPLE_W;
    localparam int DW        = hfdl_pkg::DELAY_W;
    localparam int CW        = (AW + FW > DW) ? (AW + FW) : DW;

    localparam logic [CW-1:0] DLY_LO   = CW'(1) << FW;
    localparam logic [CW-1:0] DLY_HI   = CW'(DEPTH - 3) << FW;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(DEPTH);
    localparam logic [MW-1:0] CLR_LAST = MW'(MEM_DEPTH - 1);
    localparam logic [MW-1:0] CH_BASE  = MW'(DEPTH);

    hfdl_pkg::state_t state_reg;
    hfdl_pkg::state_t state_next;

    logic [AW-1:0]        wp_reg;
    logic [MW-1:0]        clr_cnt_reg;
    logic                 out_valid_reg;
    logic signed [SW-1:0] out_data_reg;
    logic                 ch_reg;
    logic [AW-1:0]        item_wp_reg;
    logic [DW-1:0]        dly_reg;
    logic [AW-1:0]        idx_reg;
    logic [FW-1:0]        t_reg;
    logic signed [SW-1:0] rd_data_reg;

    logic signed [SW-1:0] ring_mem [MEM_DEPTH];

    logic                 accept;
    logic                 item_ch;
    logic                 out_free;
    logic                 out_load;
    logic                 wr_en;
    logic [MW-1:0]        wr_addr;
    logic signed [SW-1:0] wr_data;
    logic [AW-1:0]        rd_idx;
    logic [MW-1:0]        rd_addr;

    logic [CW-1:0]        dly_ext;
    logic [CW-1:0]        dly_clamp;
    logic [AW-1:0]        ip;
    logic [FW-1:0]        fp;
    logic [AW-1:0]        back;
    logic [AW:0]          diff;
    logic [AW:0]          diff_wrap;
    logic [AW-1:0]        idx_next;
    logic [AW-1:0]        i0;
    logic [AW-1:0]        i2;
    logic [AW-1:0]        i3;
    logic [AW:0]          s3;
    logic [AW:0]          s3_wrap;

    hfdl_pkg::interp_ctrl_t ictrl;
    logic signed [SW-1:0]   interp_sample;

    function automatic logic [MW-1:0] mem_addr(input logic ch, input logic [AW-1:0] idx);
        mem_addr = MW'(idx) + (ch ? CH_BASE : '0);
    endfunction

    assign item_ch  = (USED_CH > 1) ? item.channel : 1'b0;
    assign accept   = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;

    // read position: clamp, split, wrap behind the write position
    always_comb
    begin
        dly_ext = CW'(dly_reg);
        if (dly_ext < DLY_LO)
        begin
            dly_clamp = DLY_LO;
        end
        else if (dly_ext > DLY_HI)
        begin
            dly_clamp = DLY_HI;
        end
        else
        begin
            dly_clamp = dly_ext;
        end
        ip        = dly_clamp[AW+FW-1:FW];
        fp        = dly_clamp[FW-1:0];
        back      = ip + AW'(fp != '0);
        diff      = {1'b0, item_wp_reg} - {1'b0, back};
        diff_wrap = diff + DEPTH_X;
        idx_next  = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];
    end

    // neighbours around the read index
    always_comb
    begin
        i0      = (idx_reg == '0) ? LAST_IDX : (idx_reg - AW'(1));
        i2      = (idx_reg == LAST_IDX) ? '0 : (idx_reg + AW'(1));
        s3      = {1'b0, idx_reg} + (AW + 1)'(2);
        s3_wrap = s3 - DEPTH_X;
        i3      = (s3 >= DEPTH_X) ? s3_wrap[AW-1:0] : s3[AW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hfdl_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = hfdl_pkg::ST_IDLE;
                end
            end
            hfdl_pkg::ST_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = hfdl_pkg::ST_ADDR;
                end
            end
            hfdl_pkg::ST_ADDR: state_next = hfdl_pkg::ST_RD0;
            hfdl_pkg::ST_RD0:  state_next = hfdl_pkg::ST_RD1;
            hfdl_pkg::ST_RD1:  state_next = hfdl_pkg::ST_RD2;
            hfdl_pkg::ST_RD2:  state_next = hfdl_pkg::ST_RD3;
            hfdl_pkg::ST_RD3:  state_next = hfdl_pkg::ST_WAIT;
            hfdl_pkg::ST_WAIT: state_next = hfdl_pkg::ST_COEF;
            hfdl_pkg::ST_COEF: state_next = hfdl_pkg::ST_MUL3;
            hfdl_pkg::ST_MUL3: state_next = hfdl_pkg::ST_MUL2;
            hfdl_pkg::ST_MUL2: state_next = hfdl_pkg::ST_MUL1;
            hfdl_pkg::ST_MUL1: state_next = hfdl_pkg::ST_DONE;
            hfdl_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = hfdl_pkg::ST_IDLE;
                end
            end
            default: state_next = hfdl_pkg::ST_CLEAR;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        item.ready      = 1'b0;
        rd_idx          = idx_reg;
        out_load        = 1'b0;
        ictrl.y_load    = 1'b0;
        ictrl.y_sel     = 2'd0;
        ictrl.coef_load = 1'b0;
        ictrl.mul_en    = 1'b0;
        ictrl.step      = hfdl_pkg::MS_C3;
        unique case (state_reg)
            hfdl_pkg::ST_IDLE: item.ready = 1'b1;
            hfdl_pkg::ST_RD0:  rd_idx = i0;
            hfdl_pkg::ST_RD1:
            begin
                rd_idx       = idx_reg;
                ictrl.y_load = 1'b1;
                ictrl.y_sel  = 2'd0;
            end
            hfdl_pkg::ST_RD2:
            begin
                rd_idx       = i2;
                ictrl.y_load = 1'b1;
                ictrl.y_sel  = 2'd1;
            end
            hfdl_pkg::ST_RD3:
            begin
                rd_idx       = i3;
                ictrl.y_load = 1'b1;
                ictrl.y_sel  = 2'd2;
            end
            hfdl_pkg::ST_WAIT:
            begin
                ictrl.y_load = 1'b1;
                ictrl.y_sel  = 2'd3;
            end
            hfdl_pkg::ST_COEF: ictrl.coef_load = 1'b1;
            hfdl_pkg::ST_MUL3:
            begin
                ictrl.mul_en = 1'b1;
                ictrl.step   = hfdl_pkg::MS_C3;
            end
            hfdl_pkg::ST_MUL2:
            begin
                ictrl.mul_en = 1'b1;
                ictrl.step   = hfdl_pkg::MS_A;
            end
            hfdl_pkg::ST_MUL1:
            begin
                ictrl.mul_en = 1'b1;
                ictrl.step   = hfdl_pkg::MS_B;
            end
            hfdl_pkg::ST_DONE: out_load = out_free;
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    // memory ports: clearing pass or the incoming sample on write, sequencer on read
    always_comb
    begin
        wr_en   = (state_reg == hfdl_pkg::ST_CLEAR) || accept;
        wr_addr = (state_reg == hfdl_pkg::ST_CLEAR) ? clr_cnt_reg : mem_addr(item_ch, wp_reg);
        wr_data = (state_reg == hfdl_pkg::ST_CLEAR) ? '0 : item.sample_in;
        rd_addr = mem_addr(ch_reg, rd_idx);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hfdl_pkg::ST_CLEAR;
            wp_reg        <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == hfdl_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + MW'(1);
            end
            if (accept && item.frame_end)
            begin
                wp_reg <= (wp_reg == LAST_IDX) ? '0 : (wp_reg + AW'(1));
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg      <= item_ch;
            item_wp_reg <= wp_reg;
            dly_reg     <= item.delay_amount;
        end
        if (state_reg == hfdl_pkg::ST_ADDR)
        begin
            idx_reg <= idx_next;
            t_reg   <= FW'(0) - fp;
        end
        if (out_load)
        begin
            out_data_reg <= interp_sample;
        end
    end

    hfdl_interp u_interp
    (
        .clk    (clk),
        .ctrl   (ictrl),
        .t      (t_reg),
        .y_in   (rd_data_reg),
        .sample (interp_sample)
    );

    assign result.valid      = out_valid_reg;
    assign result.sample_out = out_data_reg;

endmodule

// File: design/hfdl_checker.sv
// hfdl_port_checks: port-level assertions for the fractional delay line
// bound to hermite_fractional_delay_line; depends on hfdl_pkg for widths
`timescale 1ns / 1ps

module hfdl_port_checks
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 item_valid,
    input logic                                 item_ready,
    input logic                                 result_valid,
    input logic                                 result_ready,
    input logic signed [hfdl_pkg::SAMPLE_W-1:0] sample_out
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    assign in_acc  = item_valid && item_ready;
    assign out_acc = result_valid && result_ready;

    // words taken but not yet delivered
    always_comb
    begin
        pending_next = pending_reg + 2'(in_acc) - 2'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pending_reg != 2'd0)
        else $error("result word without a pending item");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 2'd2)
        else $error("more than two words in flight");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !item_ready)
        else $error("item taken while the previous one is in work");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(sample_out))
        else $error("stalled result word changed");

endmodule

bind hermite_fractional_delay_line hfdl_port_checks u_hfdl_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .sample_out   (result.sample_out)
);
